// File: rtl/core/qvls_pkg.sv
// ----------------------------------------------------------------------------
// qvls_pkg
// Shared types, codes and character constants of the quoted value list
// splitter.
// ----------------------------------------------------------------------------
package qvls_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int PART_W   = 7;
    localparam int ROLE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Default part limit
    localparam int MAX_PARTS_DEFAULT = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_EXPECTED = 2'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] DELIMITER_RESET      = 8'd124;
    localparam logic [PART_W-1:0] PARTS_EXPECTED_RESET = 7'd1;

    // Characters
    localparam logic [BYTE_W-1:0] CHAR_TERM  = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CHAR_X     = 8'h58;
    localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'd57;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_E     = 8'h65;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;

    // Null mark: N plus three more bytes
    localparam int NULL_LEN = 4;
    localparam logic [1:0] NULL_FOLLOW = 2'(NULL_LEN - 1);

    // Scan modes, one-hot
    typedef enum logic [8:0] {
        MODE_START    = 9'b000000001,
        MODE_NUM      = 9'b000000010,
        MODE_NUM_SIGN = 9'b000000100,
        MODE_HEX_OPEN = 9'b000001000,
        MODE_LIT      = 9'b000010000,
        MODE_QUOTE    = 9'b000100000,
        MODE_NULLP    = 9'b001000000,
        MODE_AFTER    = 9'b010000000,
        MODE_IGNORE   = 9'b100000000
    } mode_t;

    // Byte roles
    typedef enum logic [ROLE_W-1:0] {
        ROLE_CONTENT = 2'd0,
        ROLE_DELIM   = 2'd1,
        ROLE_TERM    = 2'd2,
        ROLE_IGNORED = 2'd3
    } role_t;

    // Parse status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING     = 3'd0,
        ST_ACCEPTED    = 3'd1,
        ST_UNTERM_LIT  = 3'd2,
        ST_BAD_HEX     = 3'd3,
        ST_SHORT_NULL  = 3'd4,
        ST_BAD_NUMBER  = 3'd5,
        ST_WRONG_COUNT = 3'd6
    } status_t;

    // One result item
    typedef struct packed {
        logic [PART_W-1:0] part_number;
        role_t             byte_role;
        logic              part_closed;
        status_t           parse_status;
    } result_t;

endpackage

// File: rtl/core/quoted_value_list_splitter.sv
// ----------------------------------------------------------------------------
// quoted_value_list_splitter
// Splits a zero-terminated byte stream into delimited value parts and gives
// one classified result per byte.
// ----------------------------------------------------------------------------
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid, in_stall, text_byte                   | in
//  output   | out_valid, out_stall, part_number, byte_role,   | out
//           | part_closed, parse_status                       |
//  config   | cfg_we, cfg_index, cfg_data                     | in
//
//  One byte per cycle sustained while out_stall stays low; each byte goes
//  from the input register through the scan step into the result register,
//  from which its output transfer is made. The scan state updates in the
//  same cycle a byte moves into the result register. Reset clears the scan
//  state and both valid flags; no clearing pass follows. A stalled output
//  holds its result and backs up into the input register, which then raises
//  in_stall.
// ----------------------------------------------------------------------------
module quoted_value_list_splitter #(
    parameter int MAX_PARTS = qvls_pkg::MAX_PARTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [qvls_pkg::BYTE_W-1:0]      text_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [qvls_pkg::PART_W-1:0]      part_number,
    output logic [qvls_pkg::ROLE_W-1:0]      byte_role,
    output logic                             part_closed,
    output logic [qvls_pkg::STATUS_W-1:0]    parse_status,
    input  logic                             cfg_we,
    input  logic [qvls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qvls_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_PARTS + 1);

    logic                         in_valid_reg;
    logic [qvls_pkg::BYTE_W-1:0]  byte_reg;
    logic                         out_valid_reg;
    qvls_pkg::result_t            result_reg;
    qvls_pkg::result_t            step_result;
    logic [qvls_pkg::BYTE_W-1:0]  delimiter;
    logic [CNT_W-1:0]             part_limit;
    logic                         out_free;
    logic                         step;
    logic                         in_take;

    // Handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    qvls_cfg #(
        .MAX_PARTS (MAX_PARTS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .delimiter  (delimiter),
        .part_limit (part_limit)
    );

    // Scanner
    qvls_scan #(
        .MAX_PARTS (MAX_PARTS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .text_byte  (byte_reg),
        .delimiter  (delimiter),
        .part_limit (part_limit),
        .result     (step_result)
    );

    // Input register: hold the byte until the step takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= text_byte;
    end

    // Result register: load on a step, drop after the output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign part_number  = result_reg.part_number;
    assign byte_role    = result_reg.byte_role;
    assign part_closed  = result_reg.part_closed;
    assign parse_status = result_reg.parse_status;

endmodule

// File: rtl/core/qvls_cfg.sv
// ----------------------------------------------------------------------------
// qvls_cfg
// Configuration registers and the effective part limit.
// ----------------------------------------------------------------------------
module qvls_cfg #(
    parameter int MAX_PARTS = qvls_pkg::MAX_PARTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [qvls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qvls_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [qvls_pkg::BYTE_W-1:0]      delimiter,
    output logic [$clog2(MAX_PARTS+1)-1:0]   part_limit
);

    localparam int CNT_W = $clog2(MAX_PARTS + 1);
    localparam int LIM_W = (CNT_W > qvls_pkg::PART_W) ? CNT_W : qvls_pkg::PART_W;

    logic [qvls_pkg::BYTE_W-1:0] delimiter_reg;
    logic [qvls_pkg::PART_W-1:0] parts_expected_reg;
    logic [LIM_W-1:0]            expected_ext;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg      <= qvls_pkg::DELIMITER_RESET;
            parts_expected_reg <= qvls_pkg::PARTS_EXPECTED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qvls_pkg::CFG_DELIMITER:
                    delimiter_reg <= cfg_data[qvls_pkg::BYTE_W-1:0];
                qvls_pkg::CFG_PARTS_EXPECTED:
                    parts_expected_reg <= cfg_data[qvls_pkg::PART_W-1:0];
                default:
                    delimiter_reg <= delimiter_reg;
            endcase
        end
    end

    // Clamp the expected count to the limit
    assign expected_ext = LIM_W'(parts_expected_reg);
    assign part_limit   = (expected_ext > LIM_W'(MAX_PARTS)) ? CNT_W'(MAX_PARTS)
                                                             : CNT_W'(expected_ext);
    assign delimiter    = delimiter_reg;

endmodule

// File: rtl/core/qvls_scan.sv
// ----------------------------------------------------------------------------
// qvls_scan
// Scan state and the combinational step that classifies one byte.
// ----------------------------------------------------------------------------
module qvls_scan #(
    parameter int MAX_PARTS = qvls_pkg::MAX_PARTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [qvls_pkg::BYTE_W-1:0]     text_byte,
    input  logic [qvls_pkg::BYTE_W-1:0]     delimiter,
    input  logic [$clog2(MAX_PARTS+1)-1:0]  part_limit,
    output qvls_pkg::result_t               result
);

    localparam int CNT_W = $clog2(MAX_PARTS + 1);

    qvls_pkg::mode_t        mode_reg, mode_next;
    logic [1:0]             null_left_reg, null_left_next;
    logic                   decimal_reg, decimal_next;
    logic                   exponent_reg, exponent_next;
    logic [CNT_W-1:0]       parts_reg, parts_next;
    qvls_pkg::status_t      error_reg, error_next;

    logic                   is_term;
    logic                   is_delim;
    logic                   is_quote;
    logic                   run_after;
    logic                   run_start;
    logic                   run_num;
    logic                   do_fail;
    logic                   do_end;
    qvls_pkg::status_t      fail_code;
    qvls_pkg::role_t        fail_role;
    qvls_pkg::status_t      end_code;
    logic [1:0]             null_dec;

    assign is_term  = (text_byte == qvls_pkg::CHAR_TERM);
    assign is_delim = !is_term && (text_byte == delimiter);
    assign is_quote = (text_byte == qvls_pkg::CHAR_QUOTE);
    assign null_dec = null_left_reg - 2'd1;

    // Step one byte through the scanner
    always_comb
    begin
        mode_next      = mode_reg;
        null_left_next = null_left_reg;
        decimal_next   = decimal_reg;
        exponent_next  = exponent_reg;
        parts_next     = parts_reg;
        error_next     = error_reg;

        result.part_number  = qvls_pkg::PART_W'(parts_reg);
        result.byte_role    = qvls_pkg::ROLE_CONTENT;
        result.part_closed  = 1'b0;
        result.parse_status = qvls_pkg::ST_RUNNING;

        run_after = 1'b0;
        run_start = 1'b0;
        run_num   = 1'b0;
        do_fail   = 1'b0;
        do_end    = 1'b0;
        fail_code = qvls_pkg::ST_RUNNING;
        fail_role = qvls_pkg::ROLE_CONTENT;
        end_code  = qvls_pkg::ST_RUNNING;

        // Mode-specific handling
        case (mode_reg)
            qvls_pkg::MODE_START:
                run_start = 1'b1;
            qvls_pkg::MODE_NUM:
                run_num = 1'b1;
            qvls_pkg::MODE_NUM_SIGN:
            begin
                if (text_byte == qvls_pkg::CHAR_MINUS || text_byte == qvls_pkg::CHAR_PLUS)
                    mode_next = qvls_pkg::MODE_NUM;
                else
                    run_num = 1'b1;
            end
            qvls_pkg::MODE_HEX_OPEN:
            begin
                if (is_quote)
                    mode_next = qvls_pkg::MODE_LIT;
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = qvls_pkg::ST_BAD_HEX;
                end
            end
            qvls_pkg::MODE_LIT:
            begin
                if (is_term)
                begin
                    do_end   = 1'b1;
                    end_code = qvls_pkg::ST_UNTERM_LIT;
                end
                else if (is_quote)
                    mode_next = qvls_pkg::MODE_QUOTE;
                else
                    mode_next = qvls_pkg::MODE_LIT;
            end
            qvls_pkg::MODE_QUOTE:
            begin
                if (is_quote)
                    mode_next = qvls_pkg::MODE_LIT;
                else
                    run_after = 1'b1;
            end
            qvls_pkg::MODE_NULLP:
            begin
                if (is_term)
                begin
                    do_end   = 1'b1;
                    end_code = qvls_pkg::ST_SHORT_NULL;
                end
                else
                begin
                    null_left_next = null_dec;
                    mode_next = (null_dec == 2'd0) ? qvls_pkg::MODE_AFTER
                                                   : qvls_pkg::MODE_NULLP;
                end
            end
            qvls_pkg::MODE_AFTER:
                run_after = 1'b1;
            qvls_pkg::MODE_IGNORE:
            begin
                if (is_term)
                begin
                    do_end   = 1'b1;
                    end_code = error_reg;
                end
                else
                begin
                    result.byte_role    = qvls_pkg::ROLE_IGNORED;
                    result.parse_status = error_reg;
                end
            end
            default:
                run_start = 1'b1;
        endcase

        // Close a literal or null mark on the byte that follows it
        if (run_after)
        begin
            parts_next         = parts_next + CNT_W'(1);
            result.part_closed = 1'b1;
            if (is_delim)
            begin
                result.byte_role   = qvls_pkg::ROLE_DELIM;
                result.part_number = qvls_pkg::PART_W'(parts_reg);
                mode_next          = qvls_pkg::MODE_START;
            end
            else
            begin
                mode_next = qvls_pkg::MODE_START;
                run_start = 1'b1;
            end
        end

        // Start a new part
        if (run_start)
        begin
            mode_next = qvls_pkg::MODE_START;
            if (is_term)
            begin
                do_end   = 1'b1;
                end_code = (parts_next == part_limit) ? qvls_pkg::ST_ACCEPTED
                                                      : qvls_pkg::ST_WRONG_COUNT;
            end
            else if (parts_next >= part_limit)
            begin
                do_fail   = 1'b1;
                fail_code = qvls_pkg::ST_WRONG_COUNT;
                fail_role = qvls_pkg::ROLE_IGNORED;
            end
            else
            begin
                // The new part takes the index after any part just closed
                result.part_number = qvls_pkg::PART_W'(parts_next);
                decimal_next  = 1'b0;
                exponent_next = 1'b0;
                if (is_quote)
                    mode_next = qvls_pkg::MODE_LIT;
                else if (text_byte == qvls_pkg::CHAR_X)
                    mode_next = qvls_pkg::MODE_HEX_OPEN;
                else if (text_byte == qvls_pkg::CHAR_N)
                begin
                    null_left_next = qvls_pkg::NULL_FOLLOW;
                    mode_next      = qvls_pkg::MODE_NULLP;
                end
                else if (text_byte == qvls_pkg::CHAR_MINUS)
                    mode_next = qvls_pkg::MODE_NUM;
                else
                    run_num = 1'b1;
            end
        end

        // Advance a number
        if (run_num)
        begin
            if (is_term)
            begin
                parts_next         = parts_next + CNT_W'(1);
                result.part_closed = 1'b1;
                do_end             = 1'b1;
                end_code = (parts_next == part_limit) ? qvls_pkg::ST_ACCEPTED
                                                      : qvls_pkg::ST_WRONG_COUNT;
            end
            else if (is_delim)
            begin
                result.part_number = qvls_pkg::PART_W'(parts_next);
                parts_next         = parts_next + CNT_W'(1);
                result.part_closed = 1'b1;
                result.byte_role   = qvls_pkg::ROLE_DELIM;
                mode_next          = qvls_pkg::MODE_START;
            end
            else if (text_byte inside {[qvls_pkg::CHAR_0:qvls_pkg::CHAR_9]})
                mode_next = qvls_pkg::MODE_NUM;
            else if (text_byte == qvls_pkg::CHAR_DOT && !decimal_next)
            begin
                decimal_next = 1'b1;
                mode_next    = qvls_pkg::MODE_NUM;
            end
            else if (text_byte == qvls_pkg::CHAR_E && !exponent_next)
            begin
                exponent_next = 1'b1;
                mode_next     = qvls_pkg::MODE_NUM_SIGN;
            end
            else
            begin
                do_fail   = 1'b1;
                fail_code = qvls_pkg::ST_BAD_NUMBER;
            end
        end

        // Report an error; a terminator ends the string at once
        if (do_fail)
        begin
            if (is_term)
            begin
                do_end   = 1'b1;
                end_code = fail_code;
            end
            else
            begin
                error_next          = fail_code;
                result.parse_status = fail_code;
                result.byte_role    = fail_role;
                result.part_number  = qvls_pkg::PART_W'(parts_next);
                mode_next           = qvls_pkg::MODE_IGNORE;
            end
        end

        // End the string and clear the scan state
        if (do_end)
        begin
            result.byte_role    = qvls_pkg::ROLE_TERM;
            result.part_number  = qvls_pkg::PART_W'(parts_next);
            result.parse_status = end_code;
            mode_next           = qvls_pkg::MODE_START;
            null_left_next      = 2'd0;
            decimal_next        = 1'b0;
            exponent_next       = 1'b0;
            parts_next          = '0;
            error_next          = qvls_pkg::ST_RUNNING;
        end
    end

    // Update the scan state on each transfer through the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= qvls_pkg::MODE_START;
            null_left_reg <= 2'd0;
            decimal_reg   <= 1'b0;
            exponent_reg  <= 1'b0;
            parts_reg     <= '0;
            error_reg     <= qvls_pkg::ST_RUNNING;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            null_left_reg <= null_left_next;
            decimal_reg   <= decimal_next;
            exponent_reg  <= exponent_next;
            parts_reg     <= parts_next;
            error_reg     <= error_next;
        end
    end

endmodule

// File: dv/split_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_result_checker
// Watches the byte, result and register ports of the value list splitter.
// Keeps its own scan state and register copy, predicts one result per
// accepted byte and compares every result transfer field by field against
// the oldest prediction. Reports the mismatch count and the number of
// results still owed.
// ----------------------------------------------------------------------------
module split_result_checker
    import qvls_pkg::*;
#(
    parameter int MAX_PARTS = MAX_PARTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [PART_W-1:0]     part_number,
    input  logic [ROLE_W-1:0]     byte_role,
    input  logic                  part_closed,
    input  logic [STATUS_W-1:0]   parse_status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           mismatches,
    output int unsigned           outstanding
);

    // Scan state
    mode_t             scan_st;
    logic [1:0]        null_left;
    logic              dot_seen;
    logic              exp_seen;
    int unsigned       closed_cnt;
    status_t           err_st;

    // Register copy
    logic [BYTE_W-1:0] delim_q;
    logic [PART_W-1:0] want_q;

    // Results owed by the block, oldest first
    result_t           byte_results_q[$];

    function automatic void clear_scan();
        scan_st    = MODE_START;
        null_left  = '0;
        dot_seen   = 1'b0;
        exp_seen   = 1'b0;
        closed_cnt = 0;
        err_st     = ST_RUNNING;
    endfunction

    function automatic int unsigned part_cap();
        return (want_q > MAX_PARTS) ? MAX_PARTS : want_q;
    endfunction

    // Zero is always the terminator, whatever the register holds
    function automatic bit is_delim(input logic [BYTE_W-1:0] c);
        return (c != CHAR_TERM) && (c == delim_q);
    endfunction

    function automatic void end_str(inout result_t r, input status_t st);
        r.byte_role    = ROLE_TERM;
        r.part_number  = PART_W'(closed_cnt);
        r.parse_status = st;
        clear_scan();
    endfunction

    function automatic void end_counted(inout result_t r);
        end_str(r, (closed_cnt == part_cap()) ? ST_ACCEPTED : ST_WRONG_COUNT);
    endfunction

    // The byte that finds an error keeps its role; a terminator ends at once
    function automatic void raise_err(inout result_t r, input status_t code,
                                      input logic [BYTE_W-1:0] c, input role_t role);
        if (c == CHAR_TERM)
        begin
            end_str(r, code);
        end
        else
        begin
            err_st         = code;
            r.parse_status = code;
            r.byte_role    = role;
            r.part_number  = PART_W'(closed_cnt);
            scan_st        = MODE_IGNORE;
        end
    endfunction

    function automatic void take_content(inout result_t r, input mode_t nxt);
        r.byte_role   = ROLE_CONTENT;
        r.part_number = PART_W'(closed_cnt);
        scan_st       = nxt;
    endfunction

    function automatic void close_delim(inout result_t r);
        closed_cnt++;
        r.part_closed = 1'b1;
        r.byte_role   = ROLE_DELIM;
        r.part_number = PART_W'(closed_cnt - 1);
        scan_st       = MODE_START;
    endfunction

    // Delimiter is tested ahead of digits, so a matching digit ends the number
    function automatic void num_step(inout result_t r, input logic [BYTE_W-1:0] c);
        if (c == CHAR_TERM)
        begin
            closed_cnt++;
            r.part_closed = 1'b1;
            end_counted(r);
        end
        else if (is_delim(c))
            close_delim(r);
        else if (c >= CHAR_0 && c <= CHAR_9)
            take_content(r, MODE_NUM);
        else if (c == CHAR_DOT && !dot_seen)
        begin
            dot_seen = 1'b1;
            take_content(r, MODE_NUM);
        end
        else if (c == CHAR_E && !exp_seen)
        begin
            exp_seen = 1'b1;
            take_content(r, MODE_NUM_SIGN);
        end
        else
            raise_err(r, ST_BAD_NUMBER, c, ROLE_CONTENT);
    endfunction

    // Literal, null and minus openers win over a delimiter of the same value
    function automatic void start_step(inout result_t r, input logic [BYTE_W-1:0] c);
        if (c == CHAR_TERM)
            end_counted(r);
        else if (closed_cnt >= part_cap())
            raise_err(r, ST_WRONG_COUNT, c, ROLE_IGNORED);
        else
        begin
            dot_seen = 1'b0;
            exp_seen = 1'b0;
            if (c == CHAR_QUOTE)
                take_content(r, MODE_LIT);
            else if (c == CHAR_X)
                take_content(r, MODE_HEX_OPEN);
            else if (c == CHAR_N)
            begin
                null_left = NULL_FOLLOW;
                take_content(r, MODE_NULLP);
            end
            else if (c == CHAR_MINUS)
                take_content(r, MODE_NUM);
            else
                num_step(r, c);
        end
    endfunction

    // A finished literal or null mark closes on the next byte, delimiter or not
    function automatic void after_step(inout result_t r, input logic [BYTE_W-1:0] c);
        if (is_delim(c))
            close_delim(r);
        else
        begin
            closed_cnt++;
            r.part_closed = 1'b1;
            scan_st       = MODE_START;
            start_step(r, c);
        end
    endfunction

    function automatic result_t scan_byte(input logic [BYTE_W-1:0] c);
        result_t r;
        r = '0;
        case (scan_st)
            MODE_NUM:
                num_step(r, c);
            MODE_NUM_SIGN:
                if (c == CHAR_MINUS || c == CHAR_PLUS)
                    take_content(r, MODE_NUM);
                else
                    num_step(r, c);
            MODE_HEX_OPEN:
                if (c == CHAR_QUOTE)
                    take_content(r, MODE_LIT);
                else
                    raise_err(r, ST_BAD_HEX, c, ROLE_CONTENT);
            MODE_LIT:
                if (c == CHAR_TERM)
                    end_str(r, ST_UNTERM_LIT);
                else if (c == CHAR_QUOTE)
                    take_content(r, MODE_QUOTE);
                else
                    take_content(r, MODE_LIT);
            MODE_QUOTE:
                if (c == CHAR_QUOTE)
                    take_content(r, MODE_LIT);
                else
                    after_step(r, c);
            MODE_NULLP:
                if (c == CHAR_TERM)
                    end_str(r, ST_SHORT_NULL);
                else
                begin
                    null_left = null_left - 2'd1;
                    take_content(r, (null_left == 2'd0) ? MODE_AFTER : MODE_NULLP);
                end
            MODE_AFTER:
                after_step(r, c);
            MODE_IGNORE:
                if (c == CHAR_TERM)
                    end_str(r, err_st);
                else
                begin
                    r.byte_role    = ROLE_IGNORED;
                    r.part_number  = PART_W'(closed_cnt);
                    r.parse_status = err_st;
                end
            default:
            begin
                scan_st = MODE_START;
                start_step(r, c);
            end
        endcase
        return r;
    endfunction

    // Track transfers and register writes; compare each result transfer
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t     want;
        int unsigned faults;
        if (!rst_n)
        begin
            delim_q = DELIMITER_RESET;
            want_q  = PARTS_EXPECTED_RESET;
            clear_scan();
            byte_results_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            faults = 0;
            if (out_valid && !out_stall)
            begin
                if (byte_results_q.size() == 0)
                begin
                    $error("result transfer with no byte waiting for it");
                    faults++;
                end
                else
                begin
                    want = byte_results_q.pop_front();
                    if (part_number !== want.part_number)
                    begin
                        $error("part_number: expected %0d, got %0d",
                               want.part_number, part_number);
                        faults++;
                    end
                    if (byte_role !== want.byte_role)
                    begin
                        $error("byte_role: expected %0d, got %0d",
                               want.byte_role, byte_role);
                        faults++;
                    end
                    if (part_closed !== want.part_closed)
                    begin
                        $error("part_closed: expected %0d, got %0d",
                               want.part_closed, part_closed);
                        faults++;
                    end
                    if (parse_status !== want.parse_status)
                    begin
                        $error("parse_status: expected %0d, got %0d",
                               want.parse_status, parse_status);
                        faults++;
                    end
                end
            end
            if (in_valid && !in_stall)
                byte_results_q.push_back(scan_byte(text_byte));
            // Drop writes to indexes with no register behind them
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DELIMITER:      delim_q = cfg_data;
                    CFG_PARTS_EXPECTED: want_q  = cfg_data[PART_W-1:0];
                    default:            ;
                endcase
            end
            mismatches  <= mismatches + faults;
            outstanding <= byte_results_q.size();
        end
    end

endmodule

// File: dv/quoted_value_list_splitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_value_list_splitter_test
// Drives zero-terminated byte strings into the value list splitter: a short
// directed set of edge strings, then random well-formed part lists with some
// corruption, under a series of delimiter and part-count settings. Both
// channels idle at random, apart from a final stretch with no idling. The
// checker beside the block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module quoted_value_list_splitter_test;
    import qvls_pkg::*;

    localparam int          PART_LIMIT   = MAX_PARTS_DEFAULT;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          NUM_PHASES   = 14;

    // Register indexes with nothing behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Delimiter, raw part-count write and byte budget of each random phase
    localparam logic [7:0] PHASE_DELIM [NUM_PHASES] = '{
        8'h2C, 8'hFF, CHAR_MINUS, CHAR_QUOTE, CHAR_DOT, CHAR_E, 8'h35,
        8'h00, CHAR_X, CHAR_N, CHAR_PLUS, 8'h7C, 8'h7C, 8'h01};
    localparam logic [7:0] PHASE_COUNT [NUM_PHASES] = '{
        8'd3, 8'd0, 8'd2, 8'd2, 8'd4, 8'd3, 8'd2,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd64, 8'hC5, 8'd1};
    localparam int PHASE_BUDGET [NUM_PHASES] = '{
        120, 50, 100, 100, 100, 100, 90, 50, 70, 70, 70, 300, 150, 80};

    typedef enum int {PART_QUOTED, PART_HEX, PART_NULL, PART_NUMBER} part_kind_e;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] text_byte   = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [PART_W-1:0] part_number;
    logic [ROLE_W-1:0] byte_role;
    logic              part_closed;
    logic [STATUS_W-1:0] parse_status;
    logic              cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned       mismatches;
    int unsigned       outstanding;
    int unsigned       cycle_cnt    = 0;
    int unsigned       send_gap_pct = 11;
    int unsigned       stall_pct    = 75;
    logic [7:0]        text_q[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quoted_value_list_splitter #(
        .MAX_PARTS (PART_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .part_number  (part_number),
        .byte_role    (byte_role),
        .part_closed  (part_closed),
        .parse_status (parse_status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    split_result_checker #(
        .MAX_PARTS (PART_LIMIT)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .part_number  (part_number),
        .byte_role    (byte_role),
        .part_closed  (part_closed),
        .parse_status (parse_status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Stall the result channel at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one byte after a random gap; hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_text();
        foreach (text_q[k])
            send_byte(text_q[k]);
    endtask

    // Drop valid and wait until every result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Write both registers, then a spare index the block must ignore
    task automatic write_config(input logic [7:0] delim_val, input logic [7:0] count_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= delim_val;
        @(posedge clk);
        cfg_index <= CFG_PARTS_EXPECTED;
        cfg_data  <= count_val;
        @(posedge clk);
        cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sender idles lightly while the receiver stalls hard, then swap, then none
    task automatic pace_for(input int unsigned sent);
        if (sent < 620)
        begin
            send_gap_pct <= 11;
            stall_pct    <= 75;
        end
        else if (sent < 1240)
        begin
            send_gap_pct <= 75;
            stall_pct    <= 11;
        end
        else
        begin
            send_gap_pct <= 0;
            stall_pct    <= 0;
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic push_digits(input int unsigned count);
        repeat (count)
            text_q.push_back(CHAR_0 + 8'($urandom_range(9)));
    endtask

    // Quoted body of random bytes, doubling any quote, closed by a quote
    task automatic push_quoted();
        logic [7:0] b;
        text_q.push_back(CHAR_QUOTE);
        repeat ($urandom_range(4))
        begin
            b = 8'($urandom_range(1, 255));
            text_q.push_back(b);
            if (b == CHAR_QUOTE)
                text_q.push_back(CHAR_QUOTE);
        end
        text_q.push_back(CHAR_QUOTE);
    endtask

    // Build one string: mostly the expected number of parts, some corrupted
    task automatic build_string(input logic [7:0] sep, input int unsigned cap);
        int unsigned n;
        int unsigned pick;
        int unsigned pos;
        part_kind_e  kind;
        text_q.delete();
        pick = $urandom_range(99);
        if (pick < 80)
            n = cap;
        else if (pick < 90)
            n = cap + 1;
        else
            n = $urandom_range(cap + 1);
        for (int unsigned i = 0; i < n; i++)
        begin
            kind = part_kind_e'($urandom_range(3));
            case (kind)
                PART_QUOTED:
                    push_quoted();
                PART_HEX:
                begin
                    text_q.push_back(CHAR_X);
                    push_quoted();
                end
                PART_NULL:
                begin
                    text_q.push_back(CHAR_N);
                    repeat (NULL_LEN - 1)
                        text_q.push_back(8'($urandom_range(1, 255)));
                end
                default:
                begin
                    if ($urandom_range(1))
                        text_q.push_back(CHAR_MINUS);
                    push_digits($urandom_range(3));
                    if ($urandom_range(2) == 0)
                    begin
                        text_q.push_back(CHAR_DOT);
                        push_digits($urandom_range(2));
                    end
                    if ($urandom_range(2) == 0)
                    begin
                        text_q.push_back(CHAR_E);
                        pick = $urandom_range(2);
                        if (pick == 1)
                            text_q.push_back(CHAR_MINUS);
                        else if (pick == 2)
                            text_q.push_back(CHAR_PLUS);
                        push_digits($urandom_range(1, 2));
                    end
                end
            endcase
            // Literals may run straight into the next part; allow a trailing one
            if (i == n - 1)
            begin
                if ($urandom_range(4) == 0)
                    text_q.push_back(sep);
            end
            else if (kind == PART_NUMBER || $urandom_range(3) != 0)
                text_q.push_back(sep);
        end
        // Corrupt a few strings: overwrite, insert or cut short
        pick = $urandom_range(99);
        if (pick < 8 && text_q.size() > 0)
        begin
            pos = $urandom_range(text_q.size() - 1);
            text_q[pos] = 8'($urandom_range(255));
        end
        else if (pick < 14)
        begin
            pos = $urandom_range(text_q.size());
            text_q.insert(pos, 8'($urandom_range(255)));
        end
        else if (pick < 18 && text_q.size() > 0)
        begin
            pos = $urandom_range(text_q.size() - 1);
            while (text_q.size() > pos)
                void'(text_q.pop_back());
        end
        text_q.push_back(CHAR_TERM);
    endtask

    initial
    begin
        int unsigned sent_total;
        int unsigned sent_phase;
        int unsigned cap;
        sent_total = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings under the reset settings
        text_q.delete();
        push_text("'a''b'");
        text_q.push_back(CHAR_TERM);
        push_text("'");
        text_q.push_back(CHAR_TERM);
        push_text("XZ");
        text_q.push_back(CHAR_TERM);
        push_text("N12");
        text_q.push_back(CHAR_TERM);
        push_text("1..");
        text_q.push_back(CHAR_TERM);
        push_text("|");
        text_q.push_back(CHAR_TERM);
        push_text("e-|7");
        text_q.push_back(CHAR_TERM);
        send_text();

        // Random strings, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_config(PHASE_DELIM[p], PHASE_COUNT[p]);
            cap = PHASE_COUNT[p][PART_W-1:0];
            if (cap > PART_LIMIT)
                cap = PART_LIMIT;
            sent_phase = 0;
            while (sent_phase < PHASE_BUDGET[p])
            begin
                pace_for(sent_total);
                build_string(PHASE_DELIM[p], cap);
                send_text();
                sent_phase += text_q.size();
                sent_total += text_q.size();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
